### rtl/prf_pkg.sv
// Shared widths, types and helpers for the prime factorizer.
`default_nettype none

package prf_pkg;

  // Width of the number being factored; the ports stay at FIELD_W bits
  localparam int unsigned NUM_WIDTH   = 16;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_WIDTH);

  typedef logic [NUM_WIDTH-1:0] num_t;

  localparam num_t TRIAL_START = num_t'(2);
  localparam num_t NUM_ONE     = num_t'(1);

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  // Divider request and result
  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    num_t quot;
    num_t rem;
  } div_res_t;

  // Take the low NUM_WIDTH bits of a port word, zero-extend if wider
  function automatic num_t num_fit(input logic [FIELD_W-1:0] v);
    num_t r;
    r = '0;
    for (int i = 0; i < NUM_WIDTH; i++) begin
      if (i < FIELD_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  // Mask a factor to the port width, zero-extend if narrower
  function automatic logic [FIELD_W-1:0] factor_fit(input num_t v);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < NUM_WIDTH) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/prime_factorizer.sv
// Trial-division factorizer: controller, output word register, divider.
// Each trial divisor costs one division in the bit-serial divider; trial divisors run
// from 2 until the divisor squared exceeds the remaining cofactor.
// Inputs 0 and 1 are accepted without emitting any factor word.
// A new number is taken once the previous one has emitted its last factor word.
// Reset (rst_ni low, asynchronous) returns to idle with no pending output word.
`default_nettype none

module prime_factorizer import prf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FIELD_W-1:0] number_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [FIELD_W-1:0]      factor_o,
  output logic                    last_o
);

  state_e             state_q, state_d;
  num_t               quot_q, quot_d;
  num_t               tdiv_q, tdiv_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  num_t               pend_factor_q, pend_factor_d;
  logic               pend_last_q, pend_last_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_factor_q;
  logic               out_last_q;
  logic               out_load;
  num_t               num_m;
  div_req_t           div_req;
  div_res_t           div_res;

  assign num_m = num_fit(number_i);

  prf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // Step the trial loop
  always_comb begin
    state_d       = state_q;
    quot_d        = quot_q;
    tdiv_d        = tdiv_q;
    cnt_d         = cnt_q;
    pend_factor_d = pend_factor_q;
    pend_last_d   = pend_last_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          quot_d = num_m;
          tdiv_d = TRIAL_START;
          cnt_d  = '0;
          if (num_m > NUM_ONE) begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.quot < tdiv_q) begin
            // divisor squared exceeds the quotient: the quotient is prime
            pend_factor_d = quot_q;
            pend_last_d   = 1'b1;
            state_d       = S_EMIT;
          end else if (div_res.rem == '0) begin
            pend_factor_d = tdiv_q;
            pend_last_d   = (div_res.quot == NUM_ONE) ||
                            (cnt_q == CNT_W'(MAX_RESULTS - 1));
            quot_d        = div_res.quot;
            state_d       = S_EMIT;
          end else begin
            tdiv_d        = tdiv_q + NUM_ONE;
            div_req.start = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + CNT_W'(1);
          if (pend_last_q) begin
            state_d = S_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    div_req.dividend = quot_d;
    div_req.divisor  = tdiv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the loop words and the output word
  always_ff @(posedge clk_i) begin
    quot_q        <= quot_d;
    tdiv_q        <= tdiv_d;
    pend_factor_q <= pend_factor_d;
    pend_last_q   <= pend_last_d;
    if (out_load) begin
      out_factor_q <= factor_fit(pend_factor_q);
      out_last_q   <= pend_last_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign factor_o    = out_factor_q;
  assign last_o      = out_last_q;

  // The divider only reports back while the loop waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV))
    else $error("divider result outside the trial state");

  // The trial divisor never drops below two while a number is in work
  a_tdiv_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (tdiv_q >= TRIAL_START))
    else $error("trial divisor below two");

  // A quotient still being divided is above one
  a_quot_gt_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (quot_q > NUM_ONE))
    else $error("dividing a finished quotient");

  // Never overwrite an output word that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

endmodule

`default_nettype wire

### rtl/prf_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module prf_divider import prf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_res_t      res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  num_t                 rem_q, rem_d;
  num_t                 sh_q, sh_d;
  num_t                 dvs_q, dvs_d;

  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 ge;
  logic                 load;

  // Shift the next dividend bit into the partial remainder and test it
  assign trial = {rem_q, sh_q[NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign load  = req_i.start && !busy_q;

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
      sh_d  = {sh_q[NUM_WIDTH-2:0], ge};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(NUM_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the datapath words
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = sh_q;
  assign res_o.rem  = rem_q;

  // A finished division leaves a remainder below the divisor
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // Done is raised in the cycle after the last step, once busy has dropped
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a preceding step");

endmodule

`default_nettype wire
